>>> rtl/mals_pkg.sv
// Shared constants, types and helpers for the multi-ant Langton stepper.
package mals_pkg;

   // Grid and ant table geometry
   localparam int X_BITS    = 8;
   localparam int Y_BITS    = 7;
   localparam int NUM_ANTS  = 64;
   localparam int XMAX      = 1 << X_BITS;
   localparam int YMAX      = 1 << Y_BITS;
   localparam int CELL_BITS = X_BITS + Y_BITS;
   localparam int CELLS     = 1 << CELL_BITS;
   localparam int W_BITS    = X_BITS + 1;
   localparam int H_BITS    = Y_BITS + 1;
   localparam int ANT_BITS  = (NUM_ANTS > 1) ? $clog2(NUM_ANTS) : 1;

   // Field widths
   localparam int OP_W   = 2;
   localparam int IDX_W  = 6;
   localparam int COL_W  = 8;
   localparam int ROW_W  = 7;
   localparam int HD_W   = 2;
   localparam int STAT_W = 2;
   localparam int IDX_EXT_W = (ANT_BITS > IDX_W) ? ANT_BITS : IDX_W;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 2;

   // CSR port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RULE_DIRECT = 2'd2;

   // Headings
   localparam logic [HD_W-1:0] HD_UP    = 2'd0;
   localparam logic [HD_W-1:0] HD_RIGHT = 2'd1;
   localparam logic [HD_W-1:0] HD_DOWN  = 2'd2;
   localparam logic [HD_W-1:0] HD_LEFT  = 2'd3;

   typedef enum logic [OP_W-1:0] {
      OP_PLACE = 2'd0,
      OP_STEP  = 2'd1,
      OP_PAINT = 2'd2
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_DONE    = 2'd0,
      STAT_DIED    = 2'd1,
      STAT_IGNORED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ANT,
      ST_TURN,
      ST_MOVE
   } back_state_type;

   typedef struct packed {
      logic [W_BITS-1:0] width;
      logic [H_BITS-1:0] height;
      logic              rule_direct;
   } cfg_type;

   typedef struct packed {
      op_type            op;
      logic              op_ok;
      logic [IDX_W-1:0]  idx;
      logic              idx_ok;
      logic [COL_W-1:0]  cx;
      logic [ROW_W-1:0]  cy;
      logic              cell_ok;
   } item_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [HD_W-1:0]  hd;
   } ant_entry_type;

   typedef struct packed {
      logic [IDX_W-1:0] ant_id;
      logic [COL_W-1:0] pos_x;
      logic [ROW_W-1:0] pos_y;
      logic [HD_W-1:0]  heading;
      logic             alive;
      status_type       status;
   } rsp_type;

   function automatic logic [CELL_BITS-1:0] cell_addr(input logic [COL_W-1:0] x,
                                                       input logic [ROW_W-1:0] y);
      return {Y_BITS'(y), X_BITS'(x)};
   endfunction

endpackage

>>> rtl/mals_front.sv
// Front end: accepts request beats and classifies them for the back end.
module mals_front (
   input  mals_pkg::cfg_type                cfg,
   input  logic                             clear_busy,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [mals_pkg::OP_W-1:0]        req_op,
   input  logic [mals_pkg::IDX_W-1:0]       req_ant_index,
   input  logic [mals_pkg::COL_W-1:0]       req_cell_x,
   input  logic [mals_pkg::ROW_W-1:0]       req_cell_y,
   output logic                             push_valid,
   input  logic                             push_ready,
   output mals_pkg::item_type               push_item
);
   import mals_pkg::*;

   // no beats taken while the grid is being cleared
   assign req_ready  = push_ready && !clear_busy;
   assign push_valid = req_valid && !clear_busy;

   always_comb begin
      push_item        = '0;
      push_item.idx    = req_ant_index;
      push_item.cx     = req_cell_x;
      push_item.cy     = req_cell_y;
      push_item.idx_ok = (32'(req_ant_index) < NUM_ANTS);
      push_item.cell_ok = (32'(req_cell_x) < 32'(cfg.width)) &&
                          (32'(req_cell_y) < 32'(cfg.height));
      unique case (req_op)
         OP_PLACE: begin
            push_item.op    = OP_PLACE;
            push_item.op_ok = 1'b1;
         end
         OP_STEP: begin
            push_item.op    = OP_STEP;
            push_item.op_ok = 1'b1;
         end
         OP_PAINT: begin
            push_item.op    = OP_PAINT;
            push_item.op_ok = 1'b1;
         end
         default: begin
            push_item.op    = OP_PLACE;
            push_item.op_ok = 1'b0;
         end
      endcase
   end

endmodule

>>> rtl/mals_queue.sv
// Short FIFO of classified items between front end and back end.
module mals_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  mals_pkg::item_type  push_item,
   output logic                pop_valid,
   input  logic                pop_ready,
   output mals_pkg::item_type  pop_item
);
   import mals_pkg::*;

   localparam int QP = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QC = $clog2(QUEUE_DEPTH + 1);

   item_type        slots_ff [QUEUE_DEPTH];
   logic [QP-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QP-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QC-1:0]   count_ff, count_in;
   logic            push_fire, pop_fire;

   assign push_ready = (count_ff != QC'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slots_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == QP'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == QP'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QC'(QUEUE_DEPTH))
      else $error("queue count over depth");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push_fire && !pop_fire) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not follow push");

endmodule

>>> rtl/mals_back.sv
// Back end: sequencer over the grid memories and ant table, plus result register.
module mals_back (
   input  logic                 clock,
   input  logic                 reset,
   input  mals_pkg::cfg_type    cfg,
   output logic                 clear_busy,
   input  logic                 q_valid,
   output logic                 q_ready,
   input  mals_pkg::item_type   q_item,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mals_pkg::rsp_type    rsp
);
   import mals_pkg::*;

   // storage
   logic          color_mem [CELLS];
   logic          occ_mem   [CELLS];
   ant_entry_type ant_mem   [NUM_ANTS];

   // control registers
   back_state_type          state_ff, state_in;
   logic [CELL_BITS-1:0]    clr_addr_ff, clr_addr_in;
   logic [NUM_ANTS-1:0]     alive_ff, alive_in;
   logic [NUM_ANTS-1:0]     written_ff, written_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // payload registers
   item_type                item_ff, item_in;
   rsp_type                 rsp_ff, rsp_in;
   ant_entry_type           ant_rd_ff;
   logic                    color_rd_ff;
   logic                    occ_rd_ff;
   logic [COL_W-1:0]        nx_ff, nx_in;
   logic [ROW_W-1:0]        ny_ff, ny_in;
   logic [HD_W-1:0]         nh_ff, nh_in;
   logic                    same_ff, same_in;

   // sequencer outputs
   logic                    ant_re, ant_we;
   ant_entry_type           ant_wdata;
   logic                    alive_set, alive_clr;
   logic                    color_we, color_wdata, color_re;
   logic [CELL_BITS-1:0]    color_waddr, color_raddr;
   logic                    occ_we, occ_wdata, occ_re;
   logic [CELL_BITS-1:0]    occ_waddr, occ_raddr;
   logic                    out_load, turn_load;
   rsp_type                 out_data;

   // shared conditions
   logic                    out_free, clr_last, q_needs_ant, pop;
   logic [IDX_EXT_W-1:0]    q_idx_ext, cur_idx_ext;
   logic [ANT_BITS-1:0]     q_addr, cur_addr;
   ant_entry_type           entry;
   logic                    cur_alive, place_ok, step_ok, turn_left, occupied;
   logic [CELL_BITS-1:0]    cur_cell, new_cell;
   logic [HD_W-1:0]         new_hd;
   logic [COL_W-1:0]        new_x;
   logic [ROW_W-1:0]        new_y;
   rsp_type                 ant_view;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign clr_last    = (clr_addr_ff == CELL_BITS'(CELLS - 1));
   assign q_needs_ant = q_item.op_ok && (q_item.op != OP_PAINT);
   assign pop         = q_valid && q_ready;
   assign clear_busy  = (state_ff == ST_CLEAR);

   assign q_idx_ext   = IDX_EXT_W'(q_item.idx);
   assign q_addr      = q_idx_ext[ANT_BITS-1:0];
   assign cur_idx_ext = IDX_EXT_W'(item_ff.idx);
   assign cur_addr    = cur_idx_ext[ANT_BITS-1:0];

   // entry view: never-written entries read as reset value
   assign entry     = (item_ff.idx_ok && written_ff[cur_addr]) ? ant_rd_ff : '0;
   assign cur_alive = item_ff.idx_ok && alive_ff[cur_addr];
   assign place_ok  = item_ff.idx_ok && item_ff.cell_ok && !cur_alive;
   assign step_ok   = cur_alive &&
                      (32'(entry.col) < 32'(cfg.width)) &&
                      (32'(entry.row) < 32'(cfg.height));
   assign cur_cell  = cell_addr(entry.col, entry.row);

   // turn and move
   assign turn_left = color_rd_ff ~^ cfg.rule_direct;
   assign new_hd    = turn_left ? entry.hd + 2'd3 : entry.hd + 2'd1;

   always_comb begin
      new_x = entry.col;
      new_y = entry.row;
      case (new_hd)
         HD_UP:    new_y = (entry.row == '0) ? ROW_W'(cfg.height - 1'b1)
                                             : entry.row - 1'b1;
         HD_RIGHT: new_x = (32'(entry.col) + 1 >= 32'(cfg.width)) ? '0
                                                                 : entry.col + 1'b1;
         HD_DOWN:  new_y = (32'(entry.row) + 1 >= 32'(cfg.height)) ? '0
                                                                  : entry.row + 1'b1;
         default:  new_x = (entry.col == '0) ? COL_W'(cfg.width - 1'b1)
                                             : entry.col - 1'b1;
      endcase
   end

   assign new_cell = cell_addr(new_x, new_y);
   // a move back onto the cell just freed sees it free
   assign occupied = occ_rd_ff && !same_ff;

   always_comb begin
      ant_view         = '0;
      ant_view.ant_id  = item_ff.idx;
      ant_view.pos_x   = entry.col;
      ant_view.pos_y   = entry.row;
      ant_view.heading = entry.hd;
      ant_view.alive   = cur_alive;
      ant_view.status  = STAT_IGNORED;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_last) state_in = ST_IDLE;
         ST_IDLE:  if (pop && q_needs_ant) state_in = ST_ANT;
         ST_ANT: begin
            if (item_ff.op == OP_STEP && step_ok) begin
               state_in = ST_TURN;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_TURN:  state_in = ST_MOVE;
         ST_MOVE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // sequencer outputs
   always_comb begin
      q_ready     = 1'b0;
      ant_re      = 1'b0;
      ant_we      = 1'b0;
      ant_wdata   = '0;
      alive_set   = 1'b0;
      alive_clr   = 1'b0;
      color_we    = 1'b0;
      color_waddr = '0;
      color_wdata = 1'b0;
      color_re    = 1'b0;
      color_raddr = '0;
      occ_we      = 1'b0;
      occ_waddr   = '0;
      occ_wdata   = 1'b0;
      occ_re      = 1'b0;
      occ_raddr   = '0;
      out_load    = 1'b0;
      turn_load   = 1'b0;
      out_data    = '0;
      out_data.status = STAT_IGNORED;
      unique case (state_ff)
         ST_CLEAR: begin
            color_we    = 1'b1;
            color_waddr = clr_addr_ff;
            occ_we      = 1'b1;
            occ_waddr   = clr_addr_ff;
         end
         ST_IDLE: begin
            q_ready = q_needs_ant || out_free;
            if (pop) begin
               if (q_needs_ant) begin
                  ant_re = 1'b1;
               end else begin
                  out_load = 1'b1;
                  if (q_item.op_ok) begin
                     // paint
                     out_data.pos_x = q_item.cx;
                     out_data.pos_y = q_item.cy;
                     if (q_item.cell_ok) begin
                        out_data.status = STAT_DONE;
                        color_we    = 1'b1;
                        color_waddr = cell_addr(q_item.cx, q_item.cy);
                        color_wdata = 1'b1;
                     end
                  end
               end
            end
         end
         ST_ANT: begin
            if (item_ff.op == OP_STEP && step_ok) begin
               color_re    = 1'b1;
               color_raddr = cur_cell;
            end else if (out_free) begin
               out_load = 1'b1;
               out_data = ant_view;
               if (item_ff.op == OP_PLACE && place_ok) begin
                  ant_we        = 1'b1;
                  ant_wdata.col = item_ff.cx;
                  ant_wdata.row = item_ff.cy;
                  ant_wdata.hd  = HD_UP;
                  alive_set     = 1'b1;
                  occ_we        = 1'b1;
                  occ_waddr     = cell_addr(item_ff.cx, item_ff.cy);
                  occ_wdata     = 1'b1;
                  out_data.pos_x   = item_ff.cx;
                  out_data.pos_y   = item_ff.cy;
                  out_data.heading = HD_UP;
                  out_data.alive   = 1'b1;
                  out_data.status  = STAT_DONE;
               end
            end
         end
         ST_TURN: begin
            color_we    = 1'b1;
            color_waddr = cur_cell;
            color_wdata = !color_rd_ff;
            occ_we      = 1'b1;
            occ_waddr   = cur_cell;
            occ_wdata   = 1'b0;
            occ_re      = 1'b1;
            occ_raddr   = new_cell;
            turn_load   = 1'b1;
         end
         ST_MOVE: begin
            if (out_free) begin
               out_load      = 1'b1;
               ant_we        = 1'b1;
               ant_wdata.col = nx_ff;
               ant_wdata.row = ny_ff;
               ant_wdata.hd  = nh_ff;
               out_data.ant_id  = item_ff.idx;
               out_data.pos_x   = nx_ff;
               out_data.pos_y   = ny_ff;
               out_data.heading = nh_ff;
               if (occupied) begin
                  alive_clr       = 1'b1;
                  out_data.alive  = 1'b0;
                  out_data.status = STAT_DIED;
               end else begin
                  occ_we          = 1'b1;
                  occ_waddr       = cell_addr(nx_ff, ny_ff);
                  occ_wdata       = 1'b1;
                  out_data.alive  = 1'b1;
                  out_data.status = STAT_DONE;
               end
            end
         end
         default: ;
      endcase
   end

   // register next values
   always_comb begin
      clr_addr_in = (state_ff == ST_CLEAR) ? clr_addr_ff + 1'b1 : clr_addr_ff;
      alive_in    = alive_ff;
      written_in  = written_ff;
      if (alive_set) alive_in[cur_addr] = 1'b1;
      if (alive_clr) alive_in[cur_addr] = 1'b0;
      if (ant_we)    written_in[cur_addr] = 1'b1;
      rsp_valid_in = out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_in   = out_load ? out_data : rsp_ff;
      item_in  = pop ? q_item : item_ff;
      nx_in    = turn_load ? new_x : nx_ff;
      ny_in    = turn_load ? new_y : ny_ff;
      nh_in    = turn_load ? new_hd : nh_ff;
      same_in  = turn_load ? (new_cell == cur_cell) : same_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         alive_ff     <= '0;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         alive_ff     <= alive_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      nx_ff   <= nx_in;
      ny_ff   <= ny_in;
      nh_ff   <= nh_in;
      same_ff <= same_in;
   end

   // memories, registered reads
   always_ff @(posedge clock) begin
      if (color_we) color_mem[color_waddr] <= color_wdata;
      if (color_re) color_rd_ff <= color_mem[color_raddr];
   end

   always_ff @(posedge clock) begin
      if (occ_we) occ_mem[occ_waddr] <= occ_wdata;
      if (occ_re) occ_rd_ff <= occ_mem[occ_raddr];
   end

   always_ff @(posedge clock) begin
      if (ant_we) ant_mem[cur_addr] <= ant_wdata;
      if (ant_re) ant_rd_ff <= ant_mem[q_addr];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_clear_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && !clr_last) |=> (state_ff == ST_CLEAR))
      else $error("clearing pass ended early");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result overwrote a pending beat");

   a_turn_move: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TURN) |=> (state_ff == ST_MOVE))
      else $error("turn not followed by move");

endmodule

>>> rtl/multi_ant_langton_stepper.sv
// Top level of the multi-ant Langton stepper: CSRs, front end, queue, back end.
//
// Keeps a 256x128 one-bit color grid, a matching occupancy grid and a table of
// 64 ants, and runs place, step and paint requests on a toroidal field whose
// size is set by the grid_width and grid_height CSRs. Every request beat gives
// exactly one response beat, in order. After reset the block sweeps all 32768
// cells of both grid memories to zero, one cell a cycle; req_ready stays low
// during that pass while CSR writes are taken at any time. The front end
// classifies each beat and parks it in a two-entry queue, so requests keep
// flowing in while a response waits in the output register. The back end
// sequencer sets the pace: paint and unused op codes finish in the idle state,
// place takes an ant table read, then the update, and step an ant table read,
// color read, flip and occupancy read at the target, then commit, bounded by
// the single read and write port of each grid memory and of the ant table.
module multi_ant_langton_stepper (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [mals_pkg::OP_W-1:0]            req_op,
   input  logic [mals_pkg::IDX_W-1:0]           req_ant_index,
   input  logic [mals_pkg::COL_W-1:0]           req_cell_x,
   input  logic [mals_pkg::ROW_W-1:0]           req_cell_y,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mals_pkg::IDX_W-1:0]           rsp_ant_id,
   output logic [mals_pkg::COL_W-1:0]           rsp_pos_x,
   output logic [mals_pkg::ROW_W-1:0]           rsp_pos_y,
   output logic [mals_pkg::HD_W-1:0]            rsp_heading,
   output logic                                 rsp_alive,
   output logic [mals_pkg::STAT_W-1:0]          rsp_status,
   // CSR write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mals_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mals_pkg::CSR_DATA_W-1:0]      csr_data
);
   import mals_pkg::*;

   // raw CSR values as written
   logic [8:0]  grid_width_ff, grid_width_in;
   logic [7:0]  grid_height_ff, grid_height_in;
   logic        rule_direct_ff, rule_direct_in;

   cfg_type     cfg;
   logic        clear_busy;
   logic        push_valid, push_ready;
   item_type    push_item;
   logic        pop_valid, pop_ready;
   item_type    pop_item;
   rsp_type     rsp;

   // CSRs accept a beat every cycle
   assign csr_ready = 1'b1;

   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      rule_direct_in = rule_direct_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_GRID_WIDTH:  grid_width_in  = csr_data[8:0];
            REG_GRID_HEIGHT: grid_height_in = csr_data[7:0];
            REG_RULE_DIRECT: rule_direct_in = csr_data[0];
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= 9'd180;
         grid_height_ff <= 8'd120;
         rule_direct_ff <= 1'b1;
      end else begin
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         rule_direct_ff <= rule_direct_in;
      end
   end

   // effective field size: zero reads as one, oversize clamps to the grid
   always_comb begin
      if (grid_width_ff == '0) begin
         cfg.width = W_BITS'(1);
      end else if (32'(grid_width_ff) > XMAX) begin
         cfg.width = W_BITS'(XMAX);
      end else begin
         cfg.width = W_BITS'(grid_width_ff);
      end
      if (grid_height_ff == '0) begin
         cfg.height = H_BITS'(1);
      end else if (32'(grid_height_ff) > YMAX) begin
         cfg.height = H_BITS'(YMAX);
      end else begin
         cfg.height = H_BITS'(grid_height_ff);
      end
      cfg.rule_direct = rule_direct_ff;
   end

   mals_front u_front (
      .cfg           (cfg),
      .clear_busy    (clear_busy),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_ant_index (req_ant_index),
      .req_cell_x    (req_cell_x),
      .req_cell_y    (req_cell_y),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_item     (push_item)
   );

   mals_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   mals_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .clear_busy (clear_busy),
      .q_valid    (pop_valid),
      .q_ready    (pop_ready),
      .q_item     (pop_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   assign rsp_ant_id  = rsp.ant_id;
   assign rsp_pos_x   = rsp.pos_x;
   assign rsp_pos_y   = rsp.pos_y;
   assign rsp_heading = rsp.heading;
   assign rsp_alive   = rsp.alive;
   assign rsp_status  = rsp.status;

endmodule
